[rtl/core/astm_pkg.sv]
// ----------------------------------------------------------------------------
// Angular spectrum transfer multiply package
// Shared types, register indexes, and CORDIC constants.
// ----------------------------------------------------------------------------
package astm_pkg;

	localparam int CordicSteps = 16;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_STEP_X   = 3'd2,
		REG_STEP_Y   = 3'd3,
		REG_DISTANCE = 3'd4
	} reg_idx_t;

	function automatic logic [29:0] atan_turns(input logic [3:0] i);
		logic [29:0] r;
		begin
			case (i)
				4'd0: r = 30'd536870912;
				4'd1: r = 30'd316933406;
				4'd2: r = 30'd167458907;
				4'd3: r = 30'd85004756;
				4'd4: r = 30'd42667331;
				4'd5: r = 30'd21354465;
				4'd6: r = 30'd10679838;
				4'd7: r = 30'd5340245;
				4'd8: r = 30'd2670163;
				4'd9: r = 30'd1335087;
				4'd10: r = 30'd667544;
				4'd11: r = 30'd333772;
				4'd12: r = 30'd166886;
				4'd13: r = 30'd83443;
				4'd14: r = 30'd41721;
				default: r = 30'd20860;
			endcase
			return r;
		end
	endfunction

endpackage

[rtl/core/astm_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface astm_stream_if #(parameter type payload_t = logic) ;
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/astm_cordic_stage.sv]
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered rotation step of the rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module astm_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] x_in,
	input  logic signed [33:0] y_in,
	input  logic signed [31:0] z_in,
	output logic signed [33:0] x_out,
	output logic signed [33:0] y_out,
	output logic signed [31:0] z_out
);
	import astm_pkg::*;

	logic signed [31:0] at;
	assign at = signed'({2'b00, atan_turns(4'(STEP))});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[31]) begin
				x_out <= x_in - (y_in >>> STEP);
				y_out <= y_in + (x_in >>> STEP);
				z_out <= z_in - at;
			end else begin
				x_out <= x_in + (y_in >>> STEP);
				y_out <= y_in - (x_in >>> STEP);
				z_out <= z_in + at;
			end
		end
	end
endmodule

[rtl/core/astm_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined square root
// Restoring integer square root of a 64-bit value, two result bits a stage.
// ----------------------------------------------------------------------------
module astm_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	localparam int Stages = 16;

	logic [63:0] r_s [Stages+1];
	logic [63:0] q_s [Stages+1];

	assign r_s[0] = rad;
	assign q_s[0] = '0;

	for (genvar g = 0; g < Stages; g++) begin : g_st
		logic [63:0] r_a, q_a, r_b, q_b;
		always_comb begin
			logic [63:0] b, t;
			b = 64'd1 << (62 - 4 * g);
			r_a = r_s[g];
			q_a = q_s[g];
			t = q_a + b;
			if (r_a >= t) begin
				r_a = r_a - t;
				q_a = (q_a >> 1) + b;
			end else begin
				q_a = q_a >> 1;
			end
			b = 64'd1 << (60 - 4 * g);
			t = q_a + b;
			r_b = r_a;
			if (r_a >= t) begin
				r_b = r_a - t;
				q_b = (q_a >> 1) + b;
			end else begin
				q_b = q_a >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1] <= r_b;
				q_s[g+1] <= q_b;
			end
		end
	end

	assign root = q_s[Stages][31:0];
endmodule

[rtl/core/angular_spectrum_transfer_multiply.sv]
// ----------------------------------------------------------------------------
// Angular spectrum transfer multiply
// Multiplies one spectrum bin by the free-space transfer kernel.
// ----------------------------------------------------------------------------
// Usage: bins enter on in_ch (column, row, spec_re, spec_im) and leave on
// out_ch (out_re, out_im, evanescent), one result per bin, in order. The
// cfg_ch channel writes width, height, step_x, step_y and distance_waves by
// index; write only while no bin is in flight. Sizes above MAX_DIM saturate.
// The block is one long pipeline of 42 register stages: a bin accepted at one
// clock edge is presented on out_ch from the last stage, and a new bin can be
// taken in every cycle while the receiver does not stall the output. Most of
// the depth is in the 16-stage square root and the 16-stage CORDIC. When the
// receiver stalls, the whole pipeline holds and in_ch.ready drops as long as
// the output register stays full; nothing is lost or repeated. Reset clears
// all valid bits and loads the configuration registers with reset values.
// ----------------------------------------------------------------------------
module angular_spectrum_transfer_multiply #(
	parameter int MAX_DIM = 4096
) (
	input  logic clk,
	input  logic arst_n,
	astm_stream_if.sink   in_ch,
	astm_stream_if.sink   cfg_ch,
	astm_stream_if.source out_ch
);
	import astm_pkg::*;

	localparam int DimW = $clog2(MAX_DIM + 1);
	// Folded index magnitude covers both a 12-bit index and a full size.
	localparam int MagW = (DimW > 12) ? DimW : 12;
	localparam int Depth = 42;

	logic [DimW-1:0]   width_q, height_q;
	logic [31:0]       step_x_q, step_y_q;
	logic signed [39:0] dist_q;

	// Configuration writes.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(512);
			height_q <= DimW'(512);
			step_x_q <= 32'd686596;
			step_y_q <= 32'd686596;
			dist_q   <= 40'sd9855037604;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				REG_WIDTH: width_q <= (32'(cfg_ch.data.value[12:0]) > 32'(MAX_DIM)) ?
					DimW'(MAX_DIM) : DimW'(cfg_ch.data.value[12:0]);
				REG_HEIGHT: height_q <= (32'(cfg_ch.data.value[12:0]) > 32'(MAX_DIM)) ?
					DimW'(MAX_DIM) : DimW'(cfg_ch.data.value[12:0]);
				REG_STEP_X: step_x_q <= cfg_ch.data.value[31:0];
				REG_STEP_Y: step_y_q <= cfg_ch.data.value[31:0];
				REG_DISTANCE: dist_q <= signed'(cfg_ch.data.value[39:0]);
				default: ;
			endcase
		end
	end

	// Pipeline advance: every stage moves when the output slot is free.
	logic en;
	logic [Depth-1:0] v_q;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[Depth-2:0], in_ch.valid};
	end

	// Delay lines for the bin value.
	logic signed [31:0] re_d [40];
	logic signed [31:0] im_d [40];

	// Stage 1: fold indices.
	logic [MagW-1:0] mx_s1, my_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [MagW+1:0] fx, fy;
			fx = (MagW+2)'(in_ch.data.column) - ((MagW+2)'(in_ch.data.column) >=
				(MagW+2)'(width_q >> 1) ? (MagW+2)'(width_q) : '0);
			fy = (MagW+2)'(in_ch.data.row) - ((MagW+2)'(in_ch.data.row) >=
				(MagW+2)'(height_q >> 1) ? (MagW+2)'(height_q) : '0);
			mx_s1 <= MagW'(fx[MagW+1] ? -fx : fx);
			my_s1 <= MagW'(fy[MagW+1] ? -fy : fy);
			re_d[0] <= in_ch.data.spec_re;
			im_d[0] <= in_ch.data.spec_im;
		end
	end

	// Stage 2: direction cosines.
	logic [MagW+31:0] ax_s2, ay_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= (MagW+32)'(mx_s1) * (MagW+32)'(step_x_q);
			ay_s2 <= (MagW+32)'(my_s1) * (MagW+32)'(step_y_q);
		end
	end

	// Stage 3: squares, split in halves of the 32-bit fraction.
	logic [63:0] sx_s3, sy_s3;
	logic        big_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			big_s3 <= (ax_s2[MagW+31:32] != '0) || (ay_s2[MagW+31:32] != '0);
			sx_s3 <= ax_s2[31:0] * ax_s2[31:0];
			sy_s3 <= ay_s2[31:0] * ay_s2[31:0];
		end
	end

	// Stage 4: fsq and the radicand.
	logic [63:0] rad_s4;
	logic        ev_s4, zero_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [64:0] f;
			f = {1'b0, sx_s3} + {1'b0, sy_s3};
			ev_s4 <= big_s3 || f[64];
			zero_s4 <= (f == '0);
			rad_s4 <= 64'd0 - f[63:0];
		end
	end

	// Stages 5..20: square root.
	logic [31:0] sq;
	logic [15:0] ev_p, zero_p;
	astm_isqrt u_sqrt (.clk(clk), .en(en), .rad(rad_s4), .root(sq));
	always_ff @(posedge clk) begin
		if (en) begin
			ev_p   <= {ev_p[14:0], ev_s4};
			zero_p <= {zero_p[14:0], zero_s4};
		end
	end

	// Stage 21: root in Q1.31.
	logic [31:0] root_s21;
	logic        ev_s21;
	always_ff @(posedge clk) begin
		if (en) begin
			ev_s21 <= ev_p[15];
			root_s21 <= ev_p[15] ? 32'd0 : (zero_p[15] ? 32'h8000_0000 : {1'b0, sq[31:1]});
		end
	end

	// Stage 22: distance times root, modulo one turn in Q0.47.
	logic [46:0] prod_s22;
	logic        ev_s22;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [71:0] p;
			// The distance is sign-extended so negative distances wrap correctly.
			p = 72'(dist_q) * 72'(root_s21);
			prod_s22 <= p[46:0];
			ev_s22 <= ev_s21;
		end
	end

	// Stage 23: negate and round to a Q0.32 angle; CORDIC start point.
	logic [1:0]         quad_s23;
	logic signed [33:0] x0, y0;
	logic signed [31:0] z0;
	logic               ev_s23;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [46:0] phi;
			logic [47:0] r;
			phi = 47'd0 - prod_s22;
			r = {1'b0, phi} + 48'd16384;
			quad_s23 <= r[46:45];
			z0 <= signed'({2'b00, r[44:15]});
			x0 <= CordicGain;
			y0 <= '0;
			ev_s23 <= ev_s22;
		end
	end

	// Stages 24..39: CORDIC rotations.
	logic signed [33:0] xc [CordicSteps+1];
	logic signed [33:0] yc [CordicSteps+1];
	logic signed [31:0] zc [CordicSteps+1];
	logic [1:0]  quad_p [CordicSteps+1];
	logic        ev_c [CordicSteps+1];
	assign xc[0] = x0;
	assign yc[0] = y0;
	assign zc[0] = z0;
	assign quad_p[0] = quad_s23;
	assign ev_c[0] = ev_s23;
	for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
		astm_cordic_stage #(.STEP(g)) u_stage (
			.clk(clk), .en(en), .x_in(xc[g]), .y_in(yc[g]), .z_in(zc[g]),
			.x_out(xc[g+1]), .y_out(yc[g+1]), .z_out(zc[g+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				quad_p[g+1] <= quad_p[g];
				ev_c[g+1] <= ev_c[g];
			end
		end
	end

	// Stage 40: quadrant map and Q1.15 rounding.
	logic signed [15:0] cos_s40, sin_s40;
	logic               ev_s40;
	function automatic logic signed [15:0] rnd15(input logic signed [34:0] v);
		logic signed [34:0] t;
		begin
			t = (v + 35'sd16384) >>> 15;
			if (t > 35'sd32767) return 16'sh7fff;
			if (t < -35'sd32768) return 16'sh8000;
			return t[15:0];
		end
	endfunction
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [34:0] xe, ye, c, s;
			xe = 35'(xc[CordicSteps]);
			ye = 35'(yc[CordicSteps]);
			case (quad_p[CordicSteps])
				2'd0: begin c = xe; s = ye; end
				2'd1: begin c = -ye; s = xe; end
				2'd2: begin c = -xe; s = -ye; end
				default: begin c = ye; s = -xe; end
			endcase
			cos_s40 <= rnd15(c);
			sin_s40 <= rnd15(s);
			ev_s40 <= ev_c[CordicSteps];
		end
	end

	// Delay bin value to line up with the kernel (39 register stages).
	for (genvar g = 1; g < 40; g++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				re_d[g] <= re_d[g-1];
				im_d[g] <= im_d[g-1];
			end
		end
	end

	// Stage 41: four products.
	logic signed [47:0] rc_s41, is_s41, rs_s41, ic_s41;
	logic               ev_s41;
	always_ff @(posedge clk) begin
		if (en) begin
			rc_s41 <= 48'(re_d[39]) * 48'(cos_s40);
			is_s41 <= 48'(im_d[39]) * 48'(sin_s40);
			rs_s41 <= 48'(re_d[39]) * 48'(sin_s40);
			ic_s41 <= 48'(im_d[39]) * 48'(cos_s40);
			ev_s41 <= ev_s40;
		end
	end

	// Stage 42: sums, rounding and saturation into the output register.
	function automatic logic signed [31:0] rnd32(input logic signed [48:0] v);
		logic signed [48:0] t;
		begin
			t = (v + 49'sd16384) >>> 15;
			if (t > 49'sd2147483647) return 32'sh7fffffff;
			if (t < -49'sd2147483648) return 32'sh80000000;
			return t[31:0];
		end
	endfunction
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.out_re <= rnd32(49'(rc_s41) - 49'(is_s41));
			out_ch.data.out_im <= rnd32(49'(rs_s41) + 49'(ic_s41));
			out_ch.data.evanescent <= ev_s41;
		end
	end
	assign out_ch.valid = v_q[Depth-1];
endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Angular spectrum transfer multiply testbench
// Streams spectrum bins through the block under several register settings,
// predicts each kernel product in fixed point and checks results in order,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import astm_pkg::*;

	typedef struct packed {
		logic [11:0]        column;
		logic [11:0]        row;
		logic signed [31:0] spec_re;
		logic signed [31:0] spec_im;
	} bin_t;

	typedef struct packed {
		logic signed [31:0] out_re;
		logic signed [31:0] out_im;
		logic               evanescent;
	} res_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [39:0] value;
	} cfg_t;

	localparam int DimLimit = 4096;
	localparam int StallLimit = 4000;

	class kernel_scoreboard;
		longint unsigned size_x, size_y, step_x, step_y;
		logic [39:0] distance;
		res_t expected_q[$];
		int mismatches;
		longint atan_lut[16];

		function new();
			atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41721, 20860};
			size_x = 512;
			size_y = 512;
			step_x = 686596;
			step_y = 686596;
			distance = 40'd9855037604;
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [39:0] v);
			longint unsigned sz;
			sz = v[12:0];
			if (sz > DimLimit) sz = DimLimit;
			case (idx)
				REG_WIDTH: size_x = sz;
				REG_HEIGHT: size_y = sz;
				REG_STEP_X: step_x = v[31:0];
				REG_STEP_Y: step_y = v[31:0];
				REG_DISTANCE: distance = v;
				default: ;
			endcase
		endfunction

		function longint unsigned direction(longint unsigned idx, longint unsigned sz,
			longint unsigned stp);
			longint f;
			f = (idx < (sz >> 1)) ? longint'(idx) : longint'(idx) - longint'(sz);
			if (f < 0) f = -f;
			return longint'(f) * stp;
		endfunction

		function longint unsigned int_sqrt(longint unsigned r);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > r) b >>= 2;
			while (b != 0) begin
				if (r >= res + b) begin
					r -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint round15(longint v, longint lo, longint hi);
			longint r;
			r = (v + 16384) >>> 15;
			return r < lo ? lo : (r > hi ? hi : r);
		endfunction

		function void note_bin(bin_t b);
			longint unsigned ax, ay, sx, sy, fsq, root, phi, angle;
			longint sdist, x, y, z, xs, ys, c, s, re, im;
			logic [1:0] quad;
			res_t r;
			ax = direction(b.column, size_x, step_x);
			ay = direction(b.row, size_y, step_y);
			root = 0;
			r.evanescent = 1'b1;
			if (ax < (64'd1 << 32) && ay < (64'd1 << 32)) begin
				sx = ax * ax;
				sy = ay * ay;
				if (sx <= ~sy) begin
					fsq = sx + sy;
					r.evanescent = 1'b0;
					root = (fsq == 0) ? (64'd1 << 31) : (int_sqrt(-fsq) >> 1);
				end
			end
			sdist = {{24{distance[39]}}, distance};
			phi = (-(sdist * root)) & ((64'd1 << 47) - 1);
			angle = ((phi + 16384) >> 15) & 64'hFFFF_FFFF;
			quad = angle[31:30];
			x = 652032874;
			y = 0;
			z = angle & 64'h3FFF_FFFF;
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_lut[i];
				end else begin
					x += ys; y -= xs; z += atan_lut[i];
				end
			end
			case (quad)
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			c = round15(c, -32768, 32767);
			s = round15(s, -32768, 32767);
			re = b.spec_re;
			im = b.spec_im;
			r.out_re = 32'(round15(re * c - im * s, -64'sd2147483648, 64'sd2147483647));
			r.out_im = 32'(round15(re * s + im * c, -64'sd2147483648, 64'sd2147483647));
			expected_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = expected_q.pop_front();
			if (got.out_re !== e.out_re || got.out_im !== e.out_im
				|| got.evanescent !== e.evanescent) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected re %0d im %0d ev %0b, got re %0d im %0d ev %0b",
						e.out_re, e.out_im, e.evanescent, got.out_re, got.out_im,
						got.evanescent);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit quiet = 1'b0;
	int idle_cycles = 0;
	kernel_scoreboard sb = new();

	astm_stream_if #(.payload_t(bin_t)) in_ch ();
	astm_stream_if #(.payload_t(cfg_t)) cfg_ch ();
	astm_stream_if #(.payload_t(res_t)) out_ch ();

	angular_spectrum_transfer_multiply #(.MAX_DIM(DimLimit)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// Transactions are sampled at the rising edge; inputs only move at the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) sb.note_bin(in_ch.data);
			if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver stalls in bursts until the final quiet stretch.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if (!quiet && $urandom_range(0, 2) != 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
		end
	end

	task automatic send_bin(bin_t b);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [39:0] v);
		cfg_t w;
		drain();
		w.index = idx;
		w.value = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic bin_t random_bin();
		bin_t b;
		b.column = $urandom_range(0, 3) == 0 ? 12'($urandom()) : 12'($urandom_range(0, 600));
		b.row = $urandom_range(0, 3) == 0 ? 12'($urandom()) : 12'($urandom_range(0, 600));
		b.spec_re = $urandom();
		b.spec_im = $urandom();
		if ($urandom_range(0, 15) == 0) b.spec_re = 32'sh8000_0000;
		if ($urandom_range(0, 15) == 0) b.spec_im = 32'sh7FFF_FFFF;
		return b;
	endfunction

	task automatic send_random(int n);
		repeat (n) send_bin(random_bin());
	endtask

	function automatic logic [39:0] random_step();
		case ($urandom_range(0, 3))
			0: return 40'($urandom_range(0, 2000000));
			1: return 40'($urandom_range(0, 20000000));
			2: return 40'hFFFF_FFFF;
			default: return {8'($urandom()), 32'($urandom())};
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed bins under the reset settings.
		send_bin('{12'd0, 12'd0, 32'sd1000000, 32'sd0});
		send_bin('{12'd0, 12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
		send_bin('{12'd0, 12'd0, 32'sh8000_0000, 32'sh8000_0000});
		send_bin('{12'd255, 12'd255, 32'sh7FFF_FFFF, 32'sh8000_0000});
		send_bin('{12'd256, 12'd256, -32'sd12345, 32'sd54321});
		send_bin('{12'd511, 12'd1, 32'sd7, -32'sd7});
		send_bin('{12'd512, 12'd513, 32'sd100, 32'sd200});
		send_bin('{12'd4095, 12'd4095, 32'sh5555_5555, 32'shAAAA_AAAA});
		send_bin('{12'd2048, 12'd0, 32'sd1, 32'sd1});
		send_random(150);

		// Direction cosines just under one for small indices, past one beyond.
		write_reg(REG_STEP_X, 40'hFFFF_FFFF);
		write_reg(REG_STEP_Y, 40'd2000000000);
		send_bin('{12'd1, 12'd0, 32'sd1000, 32'sd1000});
		send_bin('{12'd0, 12'd1, 32'sd1000, 32'sd1000});
		send_bin('{12'd0, 12'd2, 32'sd1000, 32'sd1000});
		send_bin('{12'd0, 12'd0, 32'sh7FFF_FFFF, 32'sh8000_0000});
		send_random(120);

		// Degenerate and oversized sizes, extreme distances, ignored index.
		write_reg(REG_WIDTH, 40'd0);
		write_reg(REG_HEIGHT, 40'd1);
		write_reg(REG_STEP_X, 40'd1000);
		write_reg(REG_STEP_Y, 40'd0);
		write_reg(REG_DISTANCE, 40'h80_0000_0000);
		write_reg(reg_idx_t'(3'd5), 40'hFF_FFFF_FFFF);
		write_reg(reg_idx_t'(3'd7), 40'd3);
		send_bin('{12'd0, 12'd4095, 32'sd5000, -32'sd5000});
		send_random(120);

		write_reg(REG_WIDTH, 40'h1FFF);
		write_reg(REG_HEIGHT, 40'd4096);
		write_reg(REG_STEP_X, 40'd1048575);
		write_reg(REG_STEP_Y, 40'd1048576);
		write_reg(REG_DISTANCE, 40'h7F_FFFF_FFFF);
		send_bin('{12'd2047, 12'd2048, 32'sd77, 32'sd88});
		send_bin('{12'd4095, 12'd2047, -32'sd1, -32'sd1});
		send_random(120);

		write_reg(REG_WIDTH, 40'd2);
		write_reg(REG_HEIGHT, 40'd3);
		write_reg(REG_DISTANCE, 40'd0);
		send_random(80);

		// Random settings.
		repeat (4) begin
			write_reg(REG_WIDTH, {27'($urandom()), 13'($urandom())});
			write_reg(REG_HEIGHT, 40'($urandom_range(2, 4096)));
			write_reg(REG_STEP_X, random_step());
			write_reg(REG_STEP_Y, random_step());
			write_reg(REG_DISTANCE, {8'($urandom()), 32'($urandom())});
			send_random(120);
		end

		write_reg(REG_WIDTH, 40'd512);
		write_reg(REG_HEIGHT, 40'd512);
		write_reg(REG_STEP_X, 40'd686596);
		write_reg(REG_STEP_Y, 40'd686596);
		write_reg(REG_DISTANCE, 40'd9855037604);
		send_random(50);
		quiet = 1'b1;
		send_random(150);

		drain();
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
